// ===== design/aes_pkg.sv =====
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
package aes_pkg;

  localparam int unsigned KeyWordW  = 64;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned SchedDepth = 60;
  localparam int unsigned SchedAw   = 6;
  localparam int unsigned RoundW    = 4;

  localparam logic [2:0] RegKeySize = 3'd0;
  localparam logic [2:0] RegKeyW0   = 3'd1;
  localparam logic [2:0] RegKeyW3   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_INIT,
    ST_EXP_RUN,
    ST_INV_RUN,
    ST_LOAD,
    ST_ROUND,
    ST_DONE
  } aes_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load_key;     // latch initial key words into window
    logic              exp_step;     // produce next forward key word
    logic              inv_step;     // produce next inverse key word
    logic              load_block;   // latch input block at the request edge
    logic              round_step;   // run one round
    logic              first_round;  // whitening key on this cycle
    logic              last_round;   // no MixColumns
    logic              dec;
    logic              inv_key;      // round key words come from the inverse store
    logic              key_cap;      // capture the key word read last cycle
    logic [1:0]        key_slot;     // which round key word is captured
    logic [SchedAw-1:0] key_addr;    // key store read address
    logic [SchedAw-1:0] wr_addr;
    logic [RoundW-1:0] exp_nk;       // key length in words
  } aes_ctrl_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = a;
    r = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r = r ^ x;
      x = xtime(x);
    end
    gmul = r;
  endfunction

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    inv_sbox = t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  // column as 32-bit word, byte 0 in low bits
  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] o [4];
    logic [7:0] m [4];
    for (int k = 0; k < 4; k++) a[k] = w[8*k +: 8];
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else     m = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int r = 0; r < 4; r++) begin
      o[r] = 8'h00;
      for (int k = 0; k < 4; k++) o[r] = o[r] ^ gmul(m[(k + 4 - r) & 3], a[k]);
    end
    mix_col = {o[3], o[2], o[1], o[0]};
  endfunction

endpackage

// ===== design/aes_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/aes_ctrl.sv =====
// Controller: key expansion sequencing and round sequencing.
module aes_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             func,
  input  logic             sched_valid,
  input  logic [1:0]       key_size,
  output logic             busy,
  output logic             done,
  output logic             sched_set,
  output aes_pkg::aes_ctrl_t ctrl
);
  import aes_pkg::*;

  aes_state_t state, state_next;
  logic [SchedAw-1:0] idx, idx_next;     // key word index
  logic [RoundW-1:0]  rnd, rnd_next;     // round counter
  logic               dec, dec_next;
  logic [RoundW-1:0]  nk;
  logic [RoundW-1:0]  nr;
  logic [SchedAw-1:0] total;

  always_comb begin
    unique case (key_size)
      2'd0:    nk = RoundW'(4);
      2'd1:    nk = RoundW'(6);
      default: nk = RoundW'(8);
    endcase
    nr    = nk + RoundW'(6);
    total = SchedAw'({nr, 2'b00}) + SchedAw'(4);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      rnd   <= '0;
      dec   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      rnd   <= rnd_next;
      dec   <= dec_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    rnd_next   = rnd;
    dec_next   = dec;
    busy       = (state != ST_IDLE);
    done       = 1'b0;
    sched_set  = 1'b0;
    ctrl       = '0;
    ctrl.dec   = dec;
    ctrl.exp_nk = nk;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          // block is captured at the request edge
          ctrl.load_block = 1'b1;
          dec_next   = func;
          idx_next   = '0;
          state_next = sched_valid ? ST_LOAD : ST_EXP_INIT;
        end
      end
      ST_EXP_INIT: begin
        // latch the raw key into the window, whose words are then written out
        ctrl.load_key = 1'b1;
        idx_next      = '0;
        state_next    = ST_EXP_RUN;
      end
      ST_EXP_RUN: begin
        ctrl.exp_step = 1'b1;
        ctrl.wr_addr  = idx;
        if (idx == total - SchedAw'(1)) begin
          idx_next   = '0;
          state_next = ST_INV_RUN;
        end else begin
          idx_next = idx + SchedAw'(1);
        end
      end
      ST_INV_RUN: begin
        // forward words are read back one a cycle; stage 1 issues read, write follows RAM read
        ctrl.inv_step = 1'b1;
        ctrl.key_addr = idx;
        ctrl.wr_addr  = idx - SchedAw'(1);
        if (idx == total) begin
          sched_set  = 1'b1;
          idx_next   = '0;
          state_next = ST_LOAD;
        end else begin
          idx_next = idx + SchedAw'(1);
        end
      end
      ST_LOAD: begin
        // whitening key: addresses on idx 0..3, words captured on idx 1..3,
        // last word used straight from the store on idx 4
        ctrl.key_addr = (dec ? SchedAw'({nr, 2'b00}) : '0) + idx;
        if (idx != '0 && idx != SchedAw'(4)) begin
          ctrl.key_cap  = 1'b1;
          ctrl.key_slot = 2'(idx - SchedAw'(1));
        end
        if (idx == SchedAw'(4)) begin
          ctrl.first_round = 1'b1;
          ctrl.round_step  = 1'b1;
          idx_next   = '0;
          rnd_next   = RoundW'(1);
          state_next = ST_ROUND;
        end else begin
          idx_next = idx + SchedAw'(1);
        end
      end
      ST_ROUND: begin
        ctrl.inv_key  = dec;
        ctrl.key_addr = (dec ? SchedAw'({nr - rnd, 2'b00}) : SchedAw'({rnd, 2'b00})) + idx;
        if (idx != '0 && idx != SchedAw'(4)) begin
          ctrl.key_cap  = 1'b1;
          ctrl.key_slot = 2'(idx - SchedAw'(1));
        end
        if (idx == SchedAw'(4)) begin
          ctrl.round_step = 1'b1;
          ctrl.last_round = (rnd == nr);
          idx_next = '0;
          if (rnd == nr) state_next = ST_DONE;
          else rnd_next = rnd + RoundW'(1);
        end else begin
          idx_next = idx + SchedAw'(1);
        end
      end
      ST_DONE: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

// ===== design/aes_dp.sv =====
// Datapath: key expansion window, key stores, round unit and state register.
module aes_dp (
  input  logic                     clk,
  input  aes_pkg::aes_ctrl_t       ctrl,
  input  logic [4*aes_pkg::KeyWordW-1:0] key,
  input  logic [aes_pkg::BlockW-1:0] block_in,
  output logic [aes_pkg::BlockW-1:0] block_out
);
  import aes_pkg::*;

  logic [31:0] win [8];        // last nk words of the forward schedule
  logic [7:0]  rcon;
  logic [3:0]  pos;            // i mod nk
  logic [31:0] new_word;
  logic [31:0] t;
  logic        fwd_we, inv_we;
  logic [SchedAw-1:0] fwd_waddr, fwd_raddr, inv_raddr, inv_waddr;
  logic [31:0] fwd_wdata, fwd_rdata, inv_wdata, inv_rdata;
  logic [SchedAw-1:0] total;
  logic [SchedAw-1:0] rd_addr_q;
  logic [31:0] rk [3];
  logic [31:0] key_word;
  logic [BlockW-1:0] st;
  logic [BlockW-1:0] sub_out, mix_out, round_in;
  logic [RoundW-1:0] nk;
  logic [2:0]  last_w;

  assign nk     = ctrl.exp_nk;
  assign last_w = 3'(nk - RoundW'(1));
  assign total  = SchedAw'({nk + RoundW'(6), 2'b00}) + SchedAw'(4);

  // word i of the schedule computed from the window; win[nk-1] is word i-1
  always_comb begin
    t = win[last_w];
    if (pos == 4'd0) t = sub_word({t[7:0], t[31:8]}) ^ {24'h0, rcon};
    else if (nk == RoundW'(8) && pos == 4'd4) t = sub_word(t);
    new_word = win[0] ^ t;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_key) begin
      for (int i = 0; i < 8; i++) win[i] <= key[32*i +: 32];
      rcon <= 8'h01;
      pos  <= '0;
    end else if (ctrl.exp_step) begin
      if (ctrl.wr_addr >= SchedAw'(nk)) begin
        for (int i = 0; i < 7; i++) win[i] <= win[i+1];
        win[last_w] <= new_word;
        if (pos == 4'd0) rcon <= xtime(rcon);
        pos <= (pos == nk - RoundW'(1)) ? 4'd0 : pos + 4'd1;
      end
    end
  end

  // forward store write data: raw key words first, then expanded words
  always_comb begin
    fwd_we    = ctrl.exp_step;
    fwd_waddr = ctrl.wr_addr;
    fwd_wdata = (ctrl.wr_addr < SchedAw'(nk)) ? win[ctrl.wr_addr[2:0]] : new_word;
    fwd_raddr = ctrl.key_addr;
  end

  aes_ram #(.Width(32), .Depth(64)) u_fwd (
    .clk(clk), .we(fwd_we), .waddr(fwd_waddr), .wdata(fwd_wdata),
    .raddr(fwd_raddr), .rdata(fwd_rdata));

  always_ff @(posedge clk) rd_addr_q <= ctrl.key_addr;

  always_comb begin
    inv_we    = ctrl.inv_step && (ctrl.key_addr != '0);
    inv_waddr = ctrl.wr_addr;
    inv_wdata = (rd_addr_q >= SchedAw'(4) && rd_addr_q < total - SchedAw'(4))
                ? mix_col(fwd_rdata, 1'b1) : fwd_rdata;
    inv_raddr = ctrl.key_addr;
  end

  aes_ram #(.Width(32), .Depth(64)) u_inv (
    .clk(clk), .we(inv_we), .waddr(inv_waddr), .wdata(inv_wdata),
    .raddr(inv_raddr), .rdata(inv_rdata));

  // round key gathers one word a cycle; word n arrives in the cycle after its address
  assign key_word = ctrl.inv_key ? inv_rdata : fwd_rdata;

  always_ff @(posedge clk) begin
    if (ctrl.key_cap) rk[ctrl.key_slot] <= key_word;
  end

  // round function
  always_comb begin
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        if (ctrl.dec)
          sub_out[8*(r+4*c) +: 8] = inv_sbox(st[8*(r + 4*((c + 4 - r) & 3)) +: 8]);
        else
          sub_out[8*(r+4*c) +: 8] = sbox(st[8*(r + 4*((c + r) & 3)) +: 8]);
      end
    for (int c = 0; c < 4; c++)
      mix_out[32*c +: 32] = ctrl.last_round ? sub_out[32*c +: 32]
                                            : mix_col(sub_out[32*c +: 32], ctrl.dec);
    round_in = ctrl.first_round ? st : mix_out;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_block) st <= block_in;
    else if (ctrl.round_step) st <= round_in ^ {key_word, rk[2], rk[1], rk[0]};
  end

  assign block_out = st;
endmodule

// ===== design/aes_block_cipher.sv =====
// Top level of the AES-128/192/256 block cipher.
//
// Usage: write key_size and key_word0..3 through cfg_we/cfg_index/cfg_data while
// idle. A write to key_size or a key word drops the expanded schedule. Pulse
// start with func and the block while busy is low; the request and its block
// are taken at that edge. Each round reads its four key words from the
// single-read key store, then runs the round itself; the whitening key is read
// the same way before the first round, and a result cycle with done high
// follows the last round. busy drops right after, so a new request is taken
// only once the previous block is finished. A block that follows a configuration
// write first expands both schedules, forward words then inverse words, one word a cycle.
// The result appears on result_lo/result_hi for one cycle with done high;
// it cannot be stalled. Reset clears the key registers to zero, key_size to
// 128 bits and marks the schedule as not expanded.
module aes_block_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] block_lo,
  input  logic [63:0] block_hi,
  output logic        done,
  output logic [63:0] result_lo,
  output logic [63:0] result_hi
);
  import aes_pkg::*;

  logic [1:0]   key_size;
  logic [255:0] key;
  logic         sched_valid;
  logic         sched_set;
  aes_ctrl_t    ctrl;
  logic [127:0] bout;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_size    <= '0;
      key         <= '0;
      sched_valid <= 1'b0;
    end else begin
      if (sched_set) sched_valid <= 1'b1;
      if (cfg_we) begin
        if (cfg_index == RegKeySize) begin
          key_size    <= cfg_data[1:0];
          sched_valid <= 1'b0;
        end else if (cfg_index >= RegKeyW0 && cfg_index <= RegKeyW3) begin
          key[64*(cfg_index - RegKeyW0) +: 64] <= cfg_data;
          sched_valid <= 1'b0;
        end
      end
    end
  end

  aes_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .func(func), .sched_valid(sched_valid),
    .key_size(key_size), .busy(busy), .done(done), .sched_set(sched_set), .ctrl(ctrl));

  aes_dp u_dp (
    .clk(clk), .ctrl(ctrl), .key(key),
    .block_in({block_hi, block_lo}), .block_out(bout));

  assign result_lo = bout[63:0];
  assign result_hi = bout[127:64];

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("request not taken");
  a_valid_set: assert property (@(posedge clk) disable iff (rst)
    (sched_set && !cfg_we) |=> sched_valid) else $error("schedule flag not set");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the AES block cipher: driver, monitor and cipher model.
module tb;
  import aes_pkg::*;

  typedef struct {
    logic        func;
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_req_t;

  typedef struct {
    logic [63:0] lo;
    logic [63:0] hi;
  } cipher_blk_t;

  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;
  localparam int   CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        start = 1'b0;
  logic        busy;
  logic        func = 1'b0;
  logic [63:0] block_lo = '0;
  logic [63:0] block_hi = '0;
  logic        done;
  logic [63:0] result_lo;
  logic [63:0] result_hi;

  aes_block_cipher uut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // model state
  logic [1:0]  m_ksize;
  logic [63:0] m_kw [4];
  logic [31:0] m_rk [60];
  logic [31:0] m_irk [60];
  logic        m_valid;
  int          m_nr;

  cipher_req_t pending_reqs[$];
  cipher_blk_t expected_blocks[$];
  int          send_idle_pct = 0;
  bit          hold_send = 1'b0;
  int          fail_count = 0;
  int          cycle_count = 0;

  function automatic logic [7:0] gf_mult(logic [7:0] a, logic [7:0] b);
    logic [8:0] x;
    logic [7:0] r;
    x = {1'b0, a};
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= x[7:0];
      x = x << 1;
      if (x[8]) x ^= 9'h11b;
    end
    return r;
  endfunction

  function automatic logic [7:0] gf_inverse(logic [7:0] x);
    logic [7:0] r, b;
    r = 8'd1;
    b = x;
    for (int e = 254; e != 0; e >>= 1) begin
      if (e & 1) r = gf_mult(r, b);
      b = gf_mult(b, b);
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(logic [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic logic [7:0] fwd_sub(logic [7:0] x);
    logic [7:0] b;
    b = gf_inverse(x);
    return b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] rev_sub(logic [7:0] s);
    return gf_inverse(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  function automatic logic [31:0] sub_w(logic [31:0] w);
    logic [31:0] r;
    for (int j = 0; j < 4; j++) r[8*j +: 8] = fwd_sub(w[8*j +: 8]);
    return r;
  endfunction

  function automatic logic [31:0] mix_w(logic [31:0] w, logic inv);
    logic [7:0] m [4];
    logic [31:0] r;
    if (inv) m = '{8'd14, 8'd11, 8'd13, 8'd9};
    else m = '{8'd2, 8'd3, 8'd1, 8'd1};
    r = '0;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 4; k++)
        r[8*i +: 8] ^= gf_mult(m[(k + 4 - i) & 3], w[8*k +: 8]);
    return r;
  endfunction

  function automatic void expand_keys();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (m_ksize >= 2) ? 8 : (m_ksize == 1 ? 6 : 4);
    m_nr = nk + 6;
    total = 4 * (m_nr + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++) m_rk[i] = m_kw[i >> 1][32*(i & 1) +: 32];
    for (int i = nk; i < total; i++) begin
      t = m_rk[i-1];
      if (i % nk == 0) begin
        t = sub_w({t[7:0], t[31:8]}) ^ {24'h0, rc};
        rc = gf_mult(rc, 8'h02);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_w(t);
      end
      m_rk[i] = m_rk[i-nk] ^ t;
    end
    for (int i = 0; i < total; i++)
      m_irk[i] = (i >= 4 && i < total - 4) ? mix_w(m_rk[i], 1'b1) : m_rk[i];
    m_valid = 1'b1;
  endfunction

  function automatic cipher_blk_t cipher_block(cipher_req_t q);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [31:0] col;
    cipher_blk_t res;
    int src;
    if (!m_valid) expand_keys();
    for (int i = 0; i < 8; i++) begin
      s[i] = q.lo[8*i +: 8];
      s[i+8] = q.hi[8*i +: 8];
    end
    for (int i = 0; i < 16; i++)
      s[i] ^= (q.func == FuncDec) ? m_rk[4*m_nr + i/4][8*(i%4) +: 8]
                                  : m_rk[i/4][8*(i%4) +: 8];
    for (int r = 1; r <= m_nr; r++) begin
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) begin
          src = (q.func == FuncDec) ? ((c + 4 - w) & 3) : ((c + w) & 3);
          o[w + 4*c] = (q.func == FuncDec) ? rev_sub(s[w + 4*src]) : fwd_sub(s[w + 4*src]);
        end
      for (int c = 0; c < 4; c++) begin
        col = {o[4*c+3], o[4*c+2], o[4*c+1], o[4*c]};
        if (r < m_nr) col = mix_w(col, q.func == FuncDec);
        // decrypt walks rounds downward: key index Nr - r
        col ^= (q.func == FuncDec) ? m_irk[4*(m_nr - r) + c] : m_rk[4*r + c];
        for (int j = 0; j < 4; j++) s[4*c + j] = col[8*j +: 8];
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.lo[8*i +: 8] = s[i];
      res.hi[8*i +: 8] = s[i+8];
    end
    return res;
  endfunction

  // driver
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (start && !busy) begin
        expected_blocks.push_back(cipher_block('{func, block_lo, block_hi}));
        void'(pending_reqs.pop_front());
      end
      // front of the queue is the request on the ports or the next one to send
      if (pending_reqs.size() != 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        func <= pending_reqs[0].func;
        block_lo <= pending_reqs[0].lo;
        block_hi <= pending_reqs[0].hi;
      end else if (!(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cipher_blk_t want;
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $error("result with no request outstanding: %h %h", result_hi, result_lo);
        fail_count++;
      end else begin
        want = expected_blocks.pop_front();
        if (result_lo !== want.lo) begin
          $error("result_lo expected %h actual %h", want.lo, result_lo);
          fail_count++;
        end
        if (result_hi !== want.hi) begin
          $error("result_hi expected %h actual %h", want.hi, result_hi);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CycleLimit) begin
      $display("aes_block_cipher verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == RegKeySize) m_ksize = val[1:0];
    else if (idx <= RegKeyW3) m_kw[2'(idx - RegKeyW0)] = val;
    if (idx <= RegKeyW3) m_valid = 1'b0;
  endtask

  task automatic set_key(logic [1:0] ks, logic [63:0] w0, logic [63:0] w1,
                         logic [63:0] w2, logic [63:0] w3);
    write_reg(RegKeySize, {62'h0, ks});
    write_reg(RegKeyW0, w0);
    write_reg(RegKeyW0 + 3'd1, w1);
    write_reg(RegKeyW0 + 3'd2, w2);
    write_reg(RegKeyW3, w3);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++)
      pending_reqs.push_back('{logic'($urandom_range(1)), rnd64(), rnd64()});
  endtask

  initial begin
    m_ksize = '0;
    m_valid = 1'b0;
    m_nr = 10;
    for (int i = 0; i < 4; i++) m_kw[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset key, then known-answer vectors
    pending_reqs.push_back('{FuncEnc, 64'h0, 64'h0});
    pending_reqs.push_back('{FuncDec, 64'hffffffffffffffff, 64'hffffffffffffffff});
    wait_drained();
    set_key(2'd0, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h0, 64'h0);
    pending_reqs.push_back('{FuncEnc, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    pending_reqs.push_back('{FuncDec, 64'h30d8cdb78070b4c4, 64'h5ac5b47080b7cdd8});
    wait_drained();
    set_key(2'd1, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110, rnd64());
    pending_reqs.push_back('{FuncEnc, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    pending_reqs.push_back('{FuncDec, 64'h0, 64'hffffffffffffffff});
    wait_drained();
    set_key(2'd2, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 64'h1716151413121110,
            64'h1f1e1d1c1b1a1918);
    pending_reqs.push_back('{FuncEnc, 64'h7766554433221100, 64'hffeeddccbbaa9988});
    pending_reqs.push_back('{FuncDec, 64'hffffffffffffffff, 64'h0});
    wait_drained();
    // key size three acts as 256 bits; all-ones key
    set_key(2'd3, '1, '1, '1, '1);
    pending_reqs.push_back('{FuncEnc, 64'h0, 64'h0});
    pending_reqs.push_back('{FuncDec, 64'h0, 64'h0});
    wait_drained();
    // out-of-range index must leave the schedule alone
    write_reg(3'd5, rnd64());
    write_reg(3'd7, rnd64());
    pending_reqs.push_back('{FuncEnc, 64'h0123456789abcdef, 64'hfedcba9876543210});
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 7 : (phase == 1 ? 85 : 0);
      for (int k = 0; k < 4; k++) begin
        set_key(2'(k), rnd64(), rnd64(), rnd64(), rnd64());
        queue_random(phase == 1 ? 25 : 70);
        if (k == 1) begin
          // hold off until the pipe is empty
          while (pending_reqs.size() > 30) @(posedge clk);
          hold_send = 1'b1;
          @(posedge clk);
          while (start || expected_blocks.size() != 0) @(posedge clk);
          repeat (3) @(posedge clk);
          hold_send = 1'b0;
        end
        wait_drained();
      end
    end

    if (fail_count == 0) $display("aes_block_cipher verification clean");
    else $display("aes_block_cipher verification failed");
    $finish;
  end

endmodule
